[rtl/tuc_pkg.sv]
// ----------------------------------------------------------------------------
// Tick unit converter package
// Shared widths, request codes and the item type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package tuc_pkg;

  // Tick rate register width and reset value.
  localparam int RATE_W = 40;
  localparam logic [RATE_W-1:0] RATE_RESET = 40'd1000000000;

  // Magnitude of the input value, width of the scale factors, product width.
  localparam int MAG_W = 64;
  localparam int FAC_W = 52;
  localparam int NUM_W = MAG_W + FAC_W;

  // Request codes.
  typedef enum logic [3:0] {
    REQ_TICK_TO_H   = 4'd0,
    REQ_TICK_TO_MIN = 4'd1,
    REQ_TICK_TO_S   = 4'd2,
    REQ_TICK_TO_MS  = 4'd3,
    REQ_TICK_TO_NS  = 4'd4,
    REQ_TICK_TO_PS  = 4'd5,
    REQ_H_TO_TICK   = 4'd6,
    REQ_MIN_TO_TICK = 4'd7,
    REQ_S_TO_TICK   = 4'd8,
    REQ_MS_TO_TICK  = 4'd9,
    REQ_NS_TO_TICK  = 4'd10,
    REQ_PS_TO_TICK  = 4'd11
  } req_t;

  // One classified conversion: |value| * mul / div, with sign and validity.
  typedef struct packed {
    logic             invalid;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [FAC_W-1:0] mul;
    logic [FAC_W-1:0] div;
  } conv_t;

endpackage

`default_nettype wire

[rtl/tuc_front.sv]
// ----------------------------------------------------------------------------
// Tick unit converter front end
// Accepts items, decodes the request code into scale factors and splits sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tuc_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    req_type,
  input  wire logic signed [63:0]            value,
  input  wire logic [tuc_pkg::RATE_W-1:0]    tick_rate,
  input  wire logic                          q_full,
  output logic                               push_valid,
  output tuc_pkg::conv_t                     push_item
);

  logic [tuc_pkg::FAC_W-1:0] rate;
  tuc_pkg::conv_t            dec;
  logic                      f_valid;
  tuc_pkg::conv_t            f_item;

  // Decode the request into multiplier and divisor; a zero rate acts as one.
  always_comb begin
    rate = (tick_rate == '0) ? tuc_pkg::FAC_W'(1)
                             : tuc_pkg::FAC_W'(tick_rate);
    dec.invalid = 1'b0;
    dec.neg     = value[63];
    dec.mag     = value[63] ? (~$unsigned(value) + 64'd1) : $unsigned(value);
    dec.mul     = tuc_pkg::FAC_W'(1);
    dec.div     = tuc_pkg::FAC_W'(1);
    case (tuc_pkg::req_t'(req_type))
      tuc_pkg::REQ_TICK_TO_H:   dec.div = rate * 52'd3600;
      tuc_pkg::REQ_TICK_TO_MIN: dec.div = rate * 52'd60;
      tuc_pkg::REQ_TICK_TO_S:   dec.div = rate;
      tuc_pkg::REQ_TICK_TO_MS: begin
        dec.mul = 52'd1000;
        dec.div = rate;
      end
      tuc_pkg::REQ_TICK_TO_NS: begin
        dec.mul = 52'd1000000000;
        dec.div = rate;
      end
      tuc_pkg::REQ_TICK_TO_PS: begin
        dec.mul = 52'd1000000000000;
        dec.div = rate;
      end
      tuc_pkg::REQ_H_TO_TICK:   dec.mul = rate * 52'd3600;
      tuc_pkg::REQ_MIN_TO_TICK: dec.mul = rate * 52'd60;
      tuc_pkg::REQ_S_TO_TICK:   dec.mul = rate;
      tuc_pkg::REQ_MS_TO_TICK: begin
        dec.mul = rate;
        dec.div = 52'd1000;
      end
      tuc_pkg::REQ_NS_TO_TICK: begin
        dec.mul = rate;
        dec.div = 52'd1000000000;
      end
      tuc_pkg::REQ_PS_TO_TICK: begin
        dec.mul = rate;
        dec.div = 52'd1000000000000;
      end
      default: begin
        // Unused codes run through with a zero product and are flagged.
        dec.invalid = 1'b1;
        dec.mul     = '0;
      end
    endcase
  end

  // The front register empties into the queue whenever the queue has room.
  assign in_ready   = !f_valid || !q_full;
  assign push_valid = f_valid;
  assign push_item  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item <= dec;
    end
  end

endmodule

`default_nettype wire

[rtl/tuc_queue.sv]
// ----------------------------------------------------------------------------
// Tick unit converter item queue
// Two-entry queue that decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tuc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  input  tuc_pkg::conv_t      push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output tuc_pkg::conv_t      head_item
);

  tuc_pkg::conv_t entries [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           push;

  assign full       = (count == 2'd2);
  assign push       = push_valid && !full;
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop && head_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop && head_valid);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

[rtl/tuc_back.sv]
// ----------------------------------------------------------------------------
// Tick unit converter back end
// Pipelined multiply, one-bit-per-stage long division and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tuc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  tuc_pkg::conv_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [63:0]        result,
  output logic                      overflow
);

  localparam int NW = tuc_pkg::NUM_W;
  localparam int FW = tuc_pkg::FAC_W;

  typedef struct packed {
    logic          neg;
    logic          inv;
    logic [FW-1:0] rem;
    logic [NW-1:0] num;
    logic [FW-1:0] div;
  } dstage_t;

  logic          adv;
  logic          last_valid;

  // Multiply stage one: partial products.
  logic          m1_valid;
  logic          m1_neg;
  logic          m1_inv;
  logic [FW-1:0] m1_div;
  logic [57:0]   m1_pp0;
  logic [57:0]   m1_pp1;
  logic [57:0]   m1_pp2;
  logic [57:0]   m1_pp3;

  // Multiply stage two: full product.
  logic          m2_valid;
  logic          m2_neg;
  logic          m2_inv;
  logic [FW-1:0] m2_div;
  logic [NW-1:0] m2_num;

  // Division stages.
  logic          ds_valid [NW];
  dstage_t       ds       [NW];
  logic          src_valid [NW];
  dstage_t       src       [NW];

  logic [NW-1:0] quo;
  dstage_t       fin;
  logic [63:0]   res_next;
  logic          ovf_next;

  // The pipeline moves unless a finished item meets a held result.
  assign last_valid = ds_valid[NW-1];
  assign adv        = !(out_valid && !out_ready && last_valid);
  assign q_pop      = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else if (adv) begin
      m1_valid <= q_valid;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_neg <= q_item.neg;
      m1_inv <= q_item.invalid;
      m1_div <= q_item.div;
      m1_pp0 <= q_item.mag[31:0]  * q_item.mul[25:0];
      m1_pp1 <= q_item.mag[31:0]  * q_item.mul[51:26];
      m1_pp2 <= q_item.mag[63:32] * q_item.mul[25:0];
      m1_pp3 <= q_item.mag[63:32] * q_item.mul[51:26];
      m2_neg <= m1_neg;
      m2_inv <= m1_inv;
      m2_div <= m1_div;
      m2_num <= NW'(m1_pp0) + (NW'(m1_pp1) << 26) + (NW'(m1_pp2) << 32)
              + (NW'(m1_pp3) << 58);
    end
  end

  // Division: each stage brings in one product bit and yields one quotient bit.
  assign src_valid[0] = m2_valid;
  assign src[0]       = '{neg: m2_neg, inv: m2_inv, rem: '0, num: m2_num, div: m2_div};

  genvar k;
  for (k = 0; k < NW; k++) begin : g_div
    logic [FW:0] trial;
    logic        ge;
    dstage_t     nxt;

    if (k > 0) begin : g_link
      assign src_valid[k] = ds_valid[k-1];
      assign src[k]       = ds[k-1];
    end

    always_comb begin
      trial   = {src[k].rem, src[k].num[NW-1]};
      ge      = (trial >= {1'b0, src[k].div});
      nxt     = src[k];
      nxt.rem = ge ? FW'(trial - {1'b0, src[k].div}) : trial[FW-1:0];
      nxt.num = {src[k].num[NW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ds_valid[k] <= 1'b0;
      end else if (adv) begin
        ds_valid[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k] <= nxt;
      end
    end
  end

  // Restore the sign and saturate to the signed 64-bit range; invalid items give zero.
  always_comb begin
    fin      = ds[NW-1];
    quo      = fin.num;
    res_next = quo[63:0];
    ovf_next = 1'b0;
    if (fin.inv) begin
      res_next = 64'd0;
      ovf_next = 1'b1;
    end else if (fin.neg) begin
      if (quo > (NW'(1) << 63)) begin
        res_next = 64'h8000_0000_0000_0000;
        ovf_next = 1'b1;
      end else begin
        res_next = ~quo[63:0] + 64'd1;
      end
    end else if (quo[NW-1:63] != '0) begin
      res_next = 64'h7fff_ffff_ffff_ffff;
      ovf_next = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && last_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_valid) begin
      result   <= $signed(res_next);
      overflow <= ovf_next;
    end
  end

endmodule

`default_nettype wire

[rtl/tick_unit_converter.sv]
// ----------------------------------------------------------------------------
// Tick unit converter
// Converts signed 64-bit values between timer ticks and wall-clock units.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not held and returns
// one result per item, in order. Each item passes the front register, the
// queue, the split 64x52 multiply stages m1 and m2, the long division (one
// quotient bit per pipeline stage) and the output register. The division
// pipeline sets the latency; the throughput is one item per cycle unless held.
`default_nettype none

module tick_unit_converter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tuc_pkg::RATE_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [3:0]                  req_type,
  input  wire logic signed [63:0]          value,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [63:0]               result,
  output logic                             overflow
);

  logic [tuc_pkg::RATE_W-1:0] tick_rate;
  logic                       push_valid;
  tuc_pkg::conv_t             push_item;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  tuc_pkg::conv_t             q_item;

  // Tick rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= tuc_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      tick_rate <= cfg_wr_data;
    end
  end

  tuc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .value      (value),
    .tick_rate  (tick_rate),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  tuc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  tuc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .overflow  (overflow)
  );

`ifndef SYNTHESIS
  // A flagged item carries a saturated value or zero.
  a_ovf_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> (result == 64'sh7fff_ffff_ffff_ffff ||
                               result == 64'sh8000_0000_0000_0000 ||
                               result == 64'sd0))
    else $error("overflow flagged with an unsaturated result");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

[tb/tick_unit_converter_checker.sv]
// ----------------------------------------------------------------------------
// Tick unit converter checker
// Watches the input and output channels, predicts each conversion from the
// tick rate seen on the configuration port, and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_unit_converter_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tuc_pkg::RATE_W-1:0]  cfg_wr_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [3:0]                  req_type,
  input  wire logic signed [63:0]          value,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic signed [63:0]          result,
  input  wire logic                        overflow,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [63:0] result;
    logic               overflow;
  } conversion_t;

  logic [tuc_pkg::RATE_W-1:0] rate_q;
  conversion_t                conversions_due[$];

  // Exact truncated quotient of value*mul/div, saturated to signed 64 bits.
  function automatic conversion_t convert(logic [3:0] req, logic signed [63:0] v,
                                          logic [tuc_pkg::RATE_W-1:0] rate_reg);
    conversion_t       c;
    logic [127:0]      rate, mul, div, mag, quo;
    logic [63:0]       mag64;
    rate = (rate_reg == '0) ? 128'd1 : 128'(rate_reg);
    mul  = 128'd1;
    div  = 128'd1;
    c    = '0;
    case (req)
      tuc_pkg::REQ_TICK_TO_H:   div = rate * 3600;
      tuc_pkg::REQ_TICK_TO_MIN: div = rate * 60;
      tuc_pkg::REQ_TICK_TO_S:   div = rate;
      tuc_pkg::REQ_TICK_TO_MS:  begin mul = 1000; div = rate; end
      tuc_pkg::REQ_TICK_TO_NS:  begin mul = 128'd1000000000; div = rate; end
      tuc_pkg::REQ_TICK_TO_PS:  begin mul = 128'd1000000000000; div = rate; end
      tuc_pkg::REQ_H_TO_TICK:   mul = rate * 3600;
      tuc_pkg::REQ_MIN_TO_TICK: mul = rate * 60;
      tuc_pkg::REQ_S_TO_TICK:   mul = rate;
      tuc_pkg::REQ_MS_TO_TICK:  begin mul = rate; div = 1000; end
      tuc_pkg::REQ_NS_TO_TICK:  begin mul = rate; div = 128'd1000000000; end
      tuc_pkg::REQ_PS_TO_TICK:  begin mul = rate; div = 128'd1000000000000; end
      default: begin
        c.overflow = 1'b1;
        return c;
      end
    endcase
    // Magnitude of the value as a 64-bit unsigned number.
    mag64 = $unsigned(v);
    if (v[63]) mag64 = ~mag64 + 64'd1;
    mag = {64'd0, mag64};
    quo = (mag * mul) / div;
    // A negative quotient of exactly 2^63 still fits.
    if (v[63]) begin
      if (quo > 128'h8000_0000_0000_0000) begin
        c.result   = 64'h8000_0000_0000_0000;
        c.overflow = 1'b1;
      end else begin
        c.result = -quo[63:0];
      end
    end else if (quo > 128'h7fff_ffff_ffff_ffff) begin
      c.result   = 64'h7fff_ffff_ffff_ffff;
      c.overflow = 1'b1;
    end else begin
      c.result = quo[63:0];
    end
    return c;
  endfunction

  // Track the rate, predict on accepted items, compare accepted results.
  always @(posedge clk) begin
    conversion_t exp_c;
    if (rst) begin
      rate_q = tuc_pkg::RATE_RESET;
      conversions_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (conversions_due.size() == 0) begin
          $display("%0t: unexpected item result=%0d overflow=%0b", $time, result,
                   overflow);
          fail_count++;
        end else begin
          exp_c = conversions_due.pop_front();
          if (result !== exp_c.result || overflow !== exp_c.overflow) begin
            $display("%0t: expected result=%0d overflow=%0b, actual result=%0d overflow=%0b",
                     $time, exp_c.result, exp_c.overflow, result, overflow);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) conversions_due.push_back(convert(req_type, value, rate_q));
      if (cfg_wr_en) rate_q = cfg_wr_data;
    end
    pending = conversions_due.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end
endmodule

`default_nettype wire

[tb/tick_unit_converter_tb.sv]
// ----------------------------------------------------------------------------
// Tick unit converter testbench
// Drives directed and random conversions over several tick rates with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_unit_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk, rst;
  logic                        cfg_wr_en;
  logic [tuc_pkg::RATE_W-1:0]  cfg_wr_data;
  logic                        in_valid, in_ready;
  logic [3:0]                  req_type;
  logic signed [63:0]          value;
  logic                        out_valid, out_ready;
  logic signed [63:0]          result;
  logic                        overflow;
  int                          fail_count, pending;
  bit                          steady;

  tick_unit_converter uut (.*);

  tick_unit_converter_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: stalls about 36 percent of cycles except during the steady stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  // Send one item and hold it until accepted. Valid stays high afterwards
  // so that items can follow back to back; idle cycles drop it.
  task automatic send_item(logic [3:0] req, logic signed [63:0] v);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain, wait out the pipeline, then write a new tick rate.
  task automatic set_rate(logic [tuc_pkg::RATE_W-1:0] rate);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [63:0] rand_value();
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0: v = v >>> $urandom_range(63);
      1: v = $signed(64'($urandom_range(100000))) - 50000;
      2: v = {v[63], 63'h7fff_ffff_ffff_ffff};
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [tuc_pkg::RATE_W-1:0] rates[6];
    rates = '{40'd1000000000, 40'd1, 40'd1000000000000, 40'hff_ffff_ffff, 40'd0,
              40'd32768};
    rst = 1'b1;
    steady = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    req_type = '0;
    value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every code at the largest positive value, invalid codes included.
    for (int r = 0; r < 16; r++) send_item(r[3:0], 64'sh7fff_ffff_ffff_ffff);
    send_item(tuc_pkg::REQ_TICK_TO_S, 64'sh8000_0000_0000_0000);
    send_item(tuc_pkg::REQ_S_TO_TICK, 64'sh8000_0000_0000_0000);
    send_item(tuc_pkg::REQ_TICK_TO_MS, -64'sd1);
    send_item(tuc_pkg::REQ_H_TO_TICK, 64'sd0);
    send_item(tuc_pkg::REQ_PS_TO_TICK, -64'sd999);
    // At the reset rate this quotient exceeds 2^63, so it saturates and is flagged.
    send_item(tuc_pkg::REQ_MS_TO_TICK, 64'sh8000_0000_0000_0000);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) set_rate(rates[ph]);
      steady = (ph == 2);
      for (int i = 0; i < 300; i++) begin
        send_item(($urandom_range(99) < 6) ? 4'(12 + $urandom_range(3))
                                           : 4'($urandom_range(11)), rand_value());
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (140) @(negedge clk);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire

[tick_unit_converter.f]
rtl/tuc_pkg.sv
rtl/tuc_front.sv
rtl/tuc_queue.sv
rtl/tuc_back.sv
rtl/tick_unit_converter.sv
tb/tick_unit_converter_checker.sv
tb/tick_unit_converter_tb.sv
